### design/lrl_pkg.sv
// Package for the LRU list with locked reclaim.
// Holds the item structs, opcode and result-kind codes, sequencer states and
// the field write mask of the slot store. No dependencies.
package lrl_pkg;

  typedef enum logic [1:0] {
    OP_REFERENCE = 2'd0,
    OP_REMOVE    = 2'd1,
    OP_RECLAIM   = 2'd2,
    OP_SET_LOCK  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_ACK      = 2'd0,
    KIND_TAKEN    = 2'd1,
    KIND_FINISHED = 2'd2
  } kind_e;

  typedef struct packed {
    opcode_e    opcode;
    logic [5:0] slot;
    logic [5:0] scan_budget;
    logic       lock_value;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [5:0] taken_slot;
    logic [5:0] taken_count;
    logic [6:0] entries_held;
    logic       last;
  } out_item_t;

  // Which fields of a slot entry a store write touches.
  typedef struct packed {
    logic newer;
    logic older;
    logic inl;
    logic lock;
  } field_mask_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_SCAN_RD,
    S_SCAN_DEC,
    S_WR_A,
    S_WR_B,
    S_WR_C,
    S_WR_D,
    S_EMIT_RD,
    S_EMIT_LD,
    S_FINISH,
    S_ACK
  } state_e;

endpackage

### design/lru_list_with_locked_reclaim.sv
// LRU recency list over page slots with a reclaim walk that skips locked slots.
// Depends on lrl_pkg, lrl_store and lrl_takebuf.
//
// Input channel in_valid_i/in_ready_o carries one item: reference, remove,
// set-lock or reclaim. Output channel out_valid_o/out_ready_i carries results;
// the last result of an item has last set. The list lives in one slot store
// with a registered read, so every step is a read followed by masked writes.
// Set-lock or an out-of-range slot: the item is accepted, then acknowledged.
// Reference and remove: a read, a decision step and up to four link writes,
// then the acknowledge.
// Reclaim: each entry examined is read and decided; a locked one is skipped and
// a taken one is unlinked by the store write sequence. Each taken slot is then
// replayed from the take buffer with the final list size, then the closing count.
// The next item is accepted once the previous one has loaded its last result
// into the output register, even if that result still waits to be taken.
// A stalled receiver holds the sequencer only when a further result is due.
// After reset the list flags and locked marks are cleared by a pass over all
// SLOTS entries, one entry a cycle, during which in_ready_o stays low.
module lru_list_with_locked_reclaim import lrl_pkg::*; #(
  parameter int SLOTS    = 64,
  parameter int MAX_SCAN = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int SW  = $clog2(SLOTS);
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int BW  = $clog2(MAX_SCAN + 1);
  localparam int TAW = (MAX_SCAN > 1) ? $clog2(MAX_SCAN) : 1;

  state_e        state_q, state_d;
  opcode_e       op_q, op_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [SW-1:0] prev_q, prev_d;
  logic [SW-1:0] ns_q, ns_d;
  logic [SW-1:0] os_q, os_d;
  logic          push_q, push_d;
  logic          pl_q, pl_d;
  logic          wd_q, wd_d;
  logic [CW-1:0] held_q, held_d;
  logic [SW-1:0] newest_q, newest_d;
  logic [SW-1:0] oldest_q, oldest_d;
  logic [BW-1:0] budget_q, budget_d;
  logic [CW-1:0] remain_q, remain_d;
  logic [SW-1:0] cur_q, cur_d;
  logic [BW-1:0] taken_q, taken_d;
  logic [BW-1:0] emit_q, emit_d;
  logic [SW-1:0] clr_q, clr_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, out_d;

  logic          rd_en;
  logic [SW-1:0] rd_addr;
  logic [SW-1:0] rd_newer, rd_older;
  logic          rd_inl, rd_lock;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  field_mask_t   wr_mask;
  logic [SW-1:0] wr_newer, wr_older;
  logic          wr_inl, wr_lock;
  logic          tb_we, tb_re;
  logic [5:0]    tb_rdata;

  logic          in_range, can_load, accept;
  logic          do_unlink, do_push, u_mid, u_pl;
  logic [CW-1:0] u_held;
  logic [SW-1:0] u_newest, u_oldest, u_prev;
  state_e        done_state;

  lrl_store #(.SLOTS(SLOTS), .SW(SW)) u_store (
    .clk_i      (clk_i),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_newer_o (rd_newer),
    .rd_older_o (rd_older),
    .rd_inl_o   (rd_inl),
    .rd_lock_o  (rd_lock),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_mask_i  (wr_mask),
    .wr_newer_i (wr_newer),
    .wr_older_i (wr_older),
    .wr_inl_i   (wr_inl),
    .wr_lock_i  (wr_lock)
  );

  lrl_takebuf #(.DEPTH(MAX_SCAN), .AW(TAW)) u_takebuf (
    .clk_i     (clk_i),
    .wr_en_i   (tb_we),
    .wr_addr_i (taken_q[TAW-1:0]),
    .wr_data_i (6'(slot_q)),
    .rd_en_i   (tb_re),
    .rd_addr_i (emit_q[TAW-1:0]),
    .rd_data_o (tb_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign in_range    = (32'(in_item_i.slot) < SLOTS);
  assign can_load    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign done_state  = (op_q == OP_RECLAIM) ? S_SCAN_RD : S_ACK;

  // Unlink and push decision on the entry just read from the store.
  always_comb begin
    if (state_q == S_SCAN_DEC) begin
      do_unlink = !rd_lock;
      do_push   = 1'b0;
    end else begin
      do_unlink = rd_inl && ((op_q == OP_REMOVE) || (slot_q != newest_q));
      do_push   = (op_q == OP_REFERENCE) && !(rd_inl && (slot_q == newest_q));
    end
    u_held   = held_q;
    u_newest = newest_q;
    u_oldest = oldest_q;
    u_mid    = 1'b0;
    u_pl     = 1'b0;
    if (do_unlink) begin
      if (held_q <= CW'(1)) begin
        u_held = '0;
      end else if (slot_q == newest_q) begin
        u_newest = rd_older;
        u_held   = held_q - CW'(1);
      end else if (slot_q == oldest_q) begin
        u_oldest = rd_newer;
        u_held   = held_q - CW'(1);
      end else begin
        u_mid  = 1'b1;
        u_held = held_q - CW'(1);
      end
    end
    u_prev = u_newest;
    if (do_push) begin
      if (u_held == '0) begin
        u_oldest = slot_q;
      end else begin
        u_pl = 1'b1;
      end
      u_newest = slot_q;
      u_held   = u_held + CW'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == SW'(SLOTS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (in_item_i.opcode)
            OP_RECLAIM:  state_d = S_SCAN_RD;
            OP_SET_LOCK: state_d = S_ACK;
            default:     state_d = in_range ? S_DEC : S_ACK;
          endcase
        end
      end
      S_DEC: begin
        if (u_mid) state_d = S_WR_A;
        else if (u_pl) state_d = S_WR_C;
        else if (do_unlink || do_push) state_d = S_WR_D;
        else state_d = S_ACK;
      end
      S_SCAN_RD: begin
        if (budget_q == '0 || remain_q == '0) state_d = S_EMIT_RD;
        else state_d = S_SCAN_DEC;
      end
      S_SCAN_DEC: begin
        if (rd_lock) state_d = S_SCAN_RD;
        else if (u_mid) state_d = S_WR_A;
        else state_d = S_WR_D;
      end
      S_WR_A: state_d = S_WR_B;
      S_WR_B: begin
        if (pl_q) state_d = S_WR_C;
        else if (wd_q) state_d = S_WR_D;
        else state_d = done_state;
      end
      S_WR_C: state_d = wd_q ? S_WR_D : done_state;
      S_WR_D: state_d = done_state;
      S_EMIT_RD: state_d = (emit_q == taken_q) ? S_FINISH : S_EMIT_LD;
      S_EMIT_LD: begin
        if (can_load) state_d = S_EMIT_RD;
      end
      S_FINISH: begin
        if (can_load) state_d = S_IDLE;
      end
      S_ACK: begin
        if (can_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    op_d        = op_q;
    slot_d      = slot_q;
    prev_d      = prev_q;
    ns_d        = ns_q;
    os_d        = os_q;
    push_d      = push_q;
    pl_d        = pl_q;
    wd_d        = wd_q;
    held_d      = held_q;
    newest_d    = newest_q;
    oldest_d    = oldest_q;
    budget_d    = budget_q;
    remain_d    = remain_q;
    cur_d       = cur_q;
    taken_d     = taken_q;
    emit_d      = emit_q;
    clr_d       = clr_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rd_en       = 1'b0;
    rd_addr     = slot_q;
    wr_en       = 1'b0;
    wr_addr     = slot_q;
    wr_mask     = '0;
    wr_newer    = slot_q;
    wr_older    = prev_q;
    wr_inl      = push_q;
    wr_lock     = 1'b0;
    tb_we       = 1'b0;
    tb_re       = 1'b0;
    case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_mask = '{newer: 1'b0, older: 1'b0, inl: 1'b1, lock: 1'b1};
        wr_inl  = 1'b0;
        clr_d   = clr_q + SW'(1);
      end
      S_IDLE: begin
        if (accept) begin
          op_d   = in_item_i.opcode;
          slot_d = SW'(in_item_i.slot);
          case (in_item_i.opcode)
            OP_RECLAIM: begin
              budget_d = (32'(in_item_i.scan_budget) > MAX_SCAN) ? BW'(MAX_SCAN)
                                                                : BW'(in_item_i.scan_budget);
              remain_d = held_q;
              cur_d    = oldest_q;
              taken_d  = '0;
              emit_d   = '0;
            end
            OP_SET_LOCK: begin
              wr_en   = in_range;
              wr_addr = SW'(in_item_i.slot);
              wr_mask = '{newer: 1'b0, older: 1'b0, inl: 1'b0, lock: 1'b1};
              wr_lock = in_item_i.lock_value;
            end
            default: begin
              rd_en   = in_range;
              rd_addr = SW'(in_item_i.slot);
            end
          endcase
        end
      end
      S_DEC, S_SCAN_DEC: begin
        held_d   = u_held;
        newest_d = u_newest;
        oldest_d = u_oldest;
        prev_d   = u_prev;
        pl_d     = u_pl;
        push_d   = do_push;
        wd_d     = do_unlink || do_push;
        ns_d     = rd_newer;
        os_d     = rd_older;
        if (state_q == S_SCAN_DEC) begin
          budget_d = budget_q - BW'(1);
          remain_d = remain_q - CW'(1);
          cur_d    = rd_newer;
          if (!rd_lock) begin
            tb_we   = 1'b1;
            taken_d = taken_q + BW'(1);
          end
        end
      end
      S_SCAN_RD: begin
        slot_d  = cur_q;
        rd_en   = !(budget_q == '0 || remain_q == '0);
        rd_addr = cur_q;
      end
      S_WR_A: begin
        wr_en    = 1'b1;
        wr_addr  = os_q;
        wr_mask  = '{newer: 1'b1, older: 1'b0, inl: 1'b0, lock: 1'b0};
        wr_newer = ns_q;
      end
      S_WR_B: begin
        wr_en    = 1'b1;
        wr_addr  = ns_q;
        wr_mask  = '{newer: 1'b0, older: 1'b1, inl: 1'b0, lock: 1'b0};
        wr_older = os_q;
      end
      S_WR_C: begin
        wr_en    = 1'b1;
        wr_addr  = prev_q;
        wr_mask  = '{newer: 1'b1, older: 1'b0, inl: 1'b0, lock: 1'b0};
        wr_newer = slot_q;
      end
      S_WR_D: begin
        // The slot itself: linked in at the newest end, or marked as out of the list.
        wr_en   = 1'b1;
        wr_addr = slot_q;
        wr_mask = '{newer: 1'b0, older: push_q, inl: 1'b1, lock: 1'b0};
      end
      S_EMIT_RD: begin
        tb_re = (emit_q != taken_q);
      end
      S_EMIT_LD: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_d       = '{kind: KIND_TAKEN, taken_slot: tb_rdata, taken_count: 6'd0,
                          entries_held: 7'(held_q), last: 1'b0};
          emit_d      = emit_q + BW'(1);
        end
      end
      S_FINISH: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_d       = '{kind: KIND_FINISHED, taken_slot: 6'd0, taken_count: 6'(taken_q),
                          entries_held: 7'(held_q), last: 1'b1};
        end
      end
      S_ACK: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_d       = '{kind: KIND_ACK, taken_slot: 6'd0, taken_count: 6'd0,
                          entries_held: 7'(held_q), last: 1'b1};
        end
      end
      default: begin
        out_valid_d = out_valid_q && !out_ready_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      held_q      <= '0;
      newest_q    <= '0;
      oldest_q    <= '0;
      out_valid_q <= 1'b0;
      op_q        <= OP_REFERENCE;
      budget_q    <= '0;
      remain_q    <= '0;
      taken_q     <= '0;
      emit_q      <= '0;
      push_q      <= 1'b0;
      pl_q        <= 1'b0;
      wd_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      held_q      <= held_d;
      newest_q    <= newest_d;
      oldest_q    <= oldest_d;
      out_valid_q <= out_valid_d;
      op_q        <= op_d;
      budget_q    <= budget_d;
      remain_q    <= remain_d;
      taken_q     <= taken_d;
      emit_q      <= emit_d;
      push_q      <= push_d;
      pl_q        <= pl_d;
      wd_q        <= wd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    prev_q <= prev_d;
    ns_q   <= ns_d;
    os_q   <= os_d;
    cur_q  <= cur_d;
    out_q  <= out_d;
  end

endmodule

### design/lrl_store.sv
// Slot store: newer link, older link, list flag and locked mark per slot.
// One read port with registered data and one write port with a field mask.
// Depends on lrl_pkg.
module lrl_store import lrl_pkg::*; #(
  parameter int SLOTS = 64,
  parameter int SW    = 6
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [SW-1:0] rd_addr_i,
  output logic [SW-1:0] rd_newer_o,
  output logic [SW-1:0] rd_older_o,
  output logic          rd_inl_o,
  output logic          rd_lock_o,
  input  logic          wr_en_i,
  input  logic [SW-1:0] wr_addr_i,
  input  field_mask_t   wr_mask_i,
  input  logic [SW-1:0] wr_newer_i,
  input  logic [SW-1:0] wr_older_i,
  input  logic          wr_inl_i,
  input  logic          wr_lock_i
);

  logic [SW-1:0] newer_mem [SLOTS];
  logic [SW-1:0] older_mem [SLOTS];
  logic          inl_mem   [SLOTS];
  logic          lock_mem  [SLOTS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_mask_i.newer) newer_mem[wr_addr_i] <= wr_newer_i;
    if (wr_en_i && wr_mask_i.older) older_mem[wr_addr_i] <= wr_older_i;
    if (wr_en_i && wr_mask_i.inl)   inl_mem[wr_addr_i]   <= wr_inl_i;
    if (wr_en_i && wr_mask_i.lock)  lock_mem[wr_addr_i]  <= wr_lock_i;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_newer_o <= newer_mem[rd_addr_i];
      rd_older_o <= older_mem[rd_addr_i];
      rd_inl_o   <= inl_mem[rd_addr_i];
      rd_lock_o  <= lock_mem[rd_addr_i];
    end
  end

endmodule

### design/lrl_takebuf.sv
// Buffer of slots taken by one reclaim, replayed once the final count is known.
// One write port, one read port with registered data. Depends on lrl_pkg.
module lrl_takebuf import lrl_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [5:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [5:0]    rd_data_o
);

  logic [5:0] buf_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) buf_mem[wr_addr_i] <= wr_data_i;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) rd_data_o <= buf_mem[rd_addr_i];
  end

endmodule
